// File: hw/rtl/srs_pkg.sv
`default_nettype none

package srs_pkg;

  localparam int ROW_W   = 64;
  localparam int TOTAL_W = 11;
  localparam int TREE_FAN_LOG = 5;   // 32 inputs per or-tree node
  localparam int OUT_DATA_W = 16;    // found + status + entry_total, padded to bytes

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } srs_op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } srs_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_APPLY
  } srs_state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                    cmp_en;
    logic                    shift_en;
    logic signed [ROW_W-1:0] key;
  } srs_cell_ctl_t;

  // width of or-tree level lv for n leaves (level 0 is the leaves)
  function automatic int srs_level_width(input int n, input int lv);
    int w;
    w = n;
    for (int k = 0; k < lv; k++) begin
      w = (w + (1 << TREE_FAN_LOG) - 1) >> TREE_FAN_LOG;
    end
    return w;
  endfunction

  // registered levels needed to reduce n leaves to one bit
  function automatic int srs_tree_levels(input int n);
    int w;
    int l;
    w = n;
    l = 0;
    while (w > 1) begin
      w = (w + (1 << TREE_FAN_LOG) - 1) >> TREE_FAN_LOG;
      l++;
    end
    return (l < 1) ? 1 : l;
  endfunction

  // bit offset of registered level lv (1-based) in the flat tree vector
  function automatic int srs_level_offset(input int n, input int lv);
    int off;
    off = 0;
    for (int k = 1; k < lv; k++) begin
      off = off + srs_level_width(n, k);
    end
    return off;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/srs_cell.sv
`default_nettype none

module srs_cell (
  input  wire logic                            clk,
  input  wire srs_pkg::srs_cell_ctl_t          ctl,
  input  wire logic                            valid,
  input  wire logic signed [srs_pkg::ROW_W-1:0] left_val,
  input  wire logic                            left_lt,
  output logic signed [srs_pkg::ROW_W-1:0]     val_o,
  output logic                                 lt_o,
  output logic                                 eq_o
);
  import srs_pkg::*;

  logic signed [ROW_W-1:0] val_r;
  logic                    lt_r;
  logic                    eq_r;

  // compare phase: flags against the new key
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r <= valid && ($signed(val_r) < $signed(ctl.key));
      eq_r <= valid && (val_r == ctl.key);
    end
  end

  // insert: cells at or above the slot move one place up, the slot takes the key
  always_ff @(posedge clk) begin
    if (ctl.shift_en && !lt_r) begin
      val_r <= left_lt ? ctl.key : left_val;
    end
  end

  assign val_o = val_r;
  assign lt_o  = lt_r;
  assign eq_o  = eq_r;

endmodule

`default_nettype wire

// File: hw/rtl/srs_or_tree.sv
`default_nettype none

module srs_or_tree #(
  parameter int N = 1024
) (
  input  wire logic         clk,
  input  wire logic [N-1:0] leaf,
  output logic              any_o
);
  import srs_pkg::*;

  localparam int LEVELS = srs_tree_levels(N);
  localparam int TOT    = srs_level_offset(N, LEVELS + 1);
  localparam int FAN    = 1 << TREE_FAN_LOG;

  logic [TOT-1:0] tree_r;

  for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lvl
    localparam int IW   = srs_level_width(N, lv - 1);
    localparam int OW   = srs_level_width(N, lv);
    localparam int OOFF = srs_level_offset(N, lv);
    localparam int PW   = OW * FAN;

    logic [IW-1:0] src_w;
    logic [PW-1:0] pad_w;
    logic [OW-1:0] red_w;

    if (lv == 1) begin : g_first
      assign src_w = leaf;
    end else begin : g_inner
      localparam int IOFF = srs_level_offset(N, lv - 1);
      assign src_w = tree_r[IOFF +: IW];
    end

    assign pad_w = PW'(src_w);

    always_comb begin
      for (int g = 0; g < OW; g++) begin
        red_w[g] = |pad_w[g*FAN +: FAN];
      end
    end

    always_ff @(posedge clk) begin
      tree_r[OOFF +: OW] <= red_w;
    end
  end

  assign any_o = tree_r[TOT-1];

endmodule

`default_nettype wire

// File: hw/rtl/sorted_row_set_insert_lookup.sv
`default_nettype none

// channel | dir | tdata                      | tuser  | tlast
// in_     | in  | row_value[63:0]            | opcode | last_in_batch
// out_    | out | found, status, entry_total | -      | batch_end
//
// one item at a time, LEVELS = ceil(log32(CAPACITY)): an accept state, in which
// every cell compares, a wait through the LEVELS registered levels of the or-tree
// that finds a matching cell, and an apply state, after which the next is taken.
// reset clears the fsm, the entry count and the output valid; cell contents
// are don't-care until written.
// the apply cycle waits while an earlier result sits unaccepted on out_.

module sorted_row_set_insert_lookup #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [srs_pkg::ROW_W-1:0]         in_tdata,   // [63:0] row_value
  input  wire logic                              in_tuser,   // [0] opcode
  input  wire logic                              in_tlast,   // last_in_batch
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [srs_pkg::OUT_DATA_W-1:0]         out_tdata,  // [0] found, [2:1] status,
                                                             // [13:3] entry_total, [15:14] zero
  output logic                                   out_tlast   // batch_end
);
  import srs_pkg::*;

  localparam int LEVELS = srs_tree_levels(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WC_W   = $clog2(LEVELS + 1);

  srs_state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [WC_W-1:0]         wait_r, wait_nxt;
  logic signed [ROW_W-1:0] key_r;
  srs_op_t                 op_r;
  logic                    mark_r;

  logic                    out_tvalid_r, out_tvalid_nxt;
  logic                    found_r;
  srs_status_t             status_r;
  logic [TOTAL_W-1:0]      total_r;
  logic                    batch_end_r;

  // cell chain wiring
  srs_cell_ctl_t           ctl;
  logic signed [ROW_W-1:0] val_w [CAPACITY];
  logic [CAPACITY-1:0]     lt_w;
  logic [CAPACITY-1:0]     eq_w;
  logic [CAPACITY-1:0]     valid_w;
  logic                    present_w;

  logic                    accept_w;
  logic                    apply_w;     // apply cycle with a free output slot
  logic                    full_w;
  logic                    do_ins_w;
  srs_status_t             status_w;
  logic [CNT_W-1:0]        count_after_w;

  assign accept_w  = in_tvalid && in_tready;
  assign full_w    = (count_r == CNT_W'(CAPACITY));
  assign apply_w   = (state_r == S_APPLY) && (!out_tvalid_r || out_tready);

  // ---------------------------------------------------------------- cells
  assign ctl.cmp_en   = accept_w;
  assign ctl.shift_en = do_ins_w;
  assign ctl.key      = accept_w ? $signed(in_tdata) : key_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid_w[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_head
      // head cell: nothing below, so the key always lands here when it shifts
      srs_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .valid    (valid_w[i]),
        .left_val (ctl.key),
        .left_lt  (1'b1),
        .val_o    (val_w[i]),
        .lt_o     (lt_w[i]),
        .eq_o     (eq_w[i])
      );
    end else begin : g_body
      srs_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .valid    (valid_w[i]),
        .left_val (val_w[i-1]),
        .left_lt  (lt_w[i-1]),
        .val_o    (val_w[i]),
        .lt_o     (lt_w[i]),
        .eq_o     (eq_w[i])
      );
    end
  end

  // entries are distinct, so at most one cell matches: an or gives membership
  srs_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk   (clk),
    .leaf  (eq_w),
    .any_o (present_w)
  );

  // ---------------------------------------------------------------- result
  always_comb begin
    do_ins_w = 1'b0;
    status_w = ST_OK;
    if (op_r == OP_INSERT) begin
      if (present_w) begin
        status_w = ST_DUP;
      end else if (full_w) begin
        status_w = ST_FULL;
      end else begin
        do_ins_w = apply_w;
      end
    end
  end

  assign count_after_w = (op_r == OP_INSERT && !present_w && !full_w) ?
                         count_r + CNT_W'(1) : count_r;

  // ---------------------------------------------------------------- fsm
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept_w) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (wait_r == WC_W'(LEVELS - 1)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_w) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready      = (state_r == S_IDLE);
    wait_nxt       = (state_r == S_WAIT) ? wait_r + WC_W'(1) : '0;
    count_nxt      = apply_w ? count_after_w : count_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (apply_w) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      wait_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      wait_r       <= wait_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // item fields held for the whole search
  always_ff @(posedge clk) begin
    if (accept_w) begin
      key_r  <= $signed(in_tdata);
      op_r   <= srs_op_t'(in_tuser);
      mark_r <= in_tlast;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (apply_w) begin
      found_r     <= (op_r == OP_QUERY) && present_w;
      status_r    <= status_w;
      total_r     <= TOTAL_W'(count_after_w);
      batch_end_r <= mark_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'({total_r, status_r, found_r});
  assign out_tlast  = batch_end_r;

endmodule

`default_nettype wire

// File: verif/sorted_row_set_insert_lookup_tb.sv
`timescale 1ns / 100ps

module sorted_row_set_insert_lookup_tb;
  import srs_pkg::*;

  localparam int CAPACITY     = 1024;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, enough to back up the input
  localparam int DRAIN_CYCLES = 24;    // spare time after the last item drains
  localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};
  localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};

  // one request item on in_
  typedef struct {
    srs_op_t                 op;
    logic signed [ROW_W-1:0] row;
    logic                    last;
  } row_req_t;

  // one result item on out_
  typedef struct {
    logic                found;
    srs_status_t         status;
    logic [TOTAL_W-1:0]  total;
    logic                last;
  } row_resp_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [ROW_W-1:0]       in_tdata = '0;        // [63:0] row_value
  logic                   in_tuser = OP_INSERT; // [0] opcode
  logic                   in_tlast = 1'b0;      // last_in_batch
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;            // [0] found, [2:1] status,
                                                // [13:3] entry_total, [15:14] zero
  logic                   out_tlast;            // batch_end

  // stimulus and prediction state
  row_req_t                pending_rows[$];     // items waiting for the driver
  row_resp_t               expected_results[$]; // predicted results, oldest first
  logic signed [ROW_W-1:0] held_rows[$];        // predicted set contents, ascending
  logic signed [ROW_W-1:0] issued_rows[$];      // every row value sent as an insert
  row_req_t                on_bus;              // item currently offered on in_

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_trigger  = 0;  // bumped by the sequencer to ask for a long hold-off
  int hold_served   = 0;
  int hold_left     = 0;

  int mismatch_count  = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int insert_count    = 0;
  int query_hits      = 0;
  int dup_count       = 0;
  int full_count      = 0;
  int backpressure_cycles = 0;

  sorted_row_set_insert_lookup #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  // set model: lower-bound search over the held rows, then insert, flag or look up
  function automatic row_resp_t predict_row_result(input row_req_t req);
    int        lo;
    int        hi;
    int        mid;
    logic      present;
    row_resp_t r;
    lo = 0;
    hi = held_rows.size();
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_rows[mid] < req.row) lo = mid + 1;
      else hi = mid;
    end
    present = (lo < held_rows.size()) && (held_rows[lo] == req.row);
    r.found  = 1'b0;
    r.status = ST_OK;
    r.last   = req.last;
    if (req.op == OP_QUERY) begin
      r.found = present;
    end else if (present) begin
      // duplicate wins over full
      r.status = ST_DUP;
    end else if (held_rows.size() >= CAPACITY) begin
      r.status = ST_FULL;
    end else begin
      held_rows.insert(lo, req.row);
    end
    r.total = TOTAL_W'(held_rows.size());
    return r;
  endfunction

  // row values biased toward collisions, extremes and neighbors of known rows
  function automatic logic signed [ROW_W-1:0] pick_row_value();
    int                      sel;
    longint                  off;
    logic signed [ROW_W-1:0] v;
    sel = $urandom_range(0, 9);
    v = {$urandom, $urandom};
    case (sel)
      3, 4: begin
        off = longint'($urandom_range(0, 80)) - 40;
        v = off;
      end
      5: begin
        case ($urandom_range(0, 5))
          0: v = ROW_MIN;
          1: v = ROW_MAX;
          2: v = ROW_MIN + 1;
          3: v = ROW_MAX - 1;
          4: v = '0;
          default: v = '1;
        endcase
      end
      6, 7, 8: begin
        if (issued_rows.size() != 0) v = issued_rows[$urandom_range(0, issued_rows.size() - 1)];
      end
      9: begin
        if (issued_rows.size() != 0) begin
          v = issued_rows[$urandom_range(0, issued_rows.size() - 1)];
          v = $urandom_range(0, 1) ? v + 1 : v - 1;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_row(input srs_op_t op, input logic signed [ROW_W-1:0] row,
                           input logic last);
    row_req_t req;
    req.op   = op;
    req.row  = row;
    req.last = last;
    pending_rows.push_back(req);
    if (op == OP_INSERT) issued_rows.push_back(row);
  endtask

  task automatic queue_random_rows(input int count, input int insert_pct);
    srs_op_t op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_QUERY;
      queue_row(op, pick_row_value(), $urandom_range(0, 7) == 0);
    end
  endtask

  // sender pause: nothing pending, nothing offered, nothing outstanding
  task automatic wait_drained();
    while (pending_rows.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // driver: predict on each accepted item, then offer the next one or idle
  always @(posedge clk) begin : row_driver
    row_resp_t resp;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && !in_tready) backpressure_cycles++;
      if (in_tvalid && in_tready) begin
        resp = predict_row_result(on_bus);
        expected_results.push_back(resp);
        items_sent++;
        if (on_bus.op == OP_INSERT) insert_count++;
        if (resp.found) query_hits++;
        if (resp.status == ST_DUP) dup_count++;
        if (resp.status == ST_FULL) full_count++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_rows.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_rows.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= on_bus.row;
          in_tuser  <= on_bus.op;
          in_tlast  <= on_bus.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready: random stalls, or a long hold-off when the sequencer asks
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_trigger) begin
      hold_served <= hold_trigger;
      hold_left   <= HOLD_CYCLES;
      out_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor: each accepted result against the oldest prediction
  always @(posedge clk) begin : result_check
    row_resp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none, got data=%h last=%b",
                 $time, out_tdata, out_tlast);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_tdata[0] !== want.found || out_tdata[2:1] !== want.status ||
            out_tdata[3 +: TOTAL_W] !== want.total || out_tlast !== want.last ||
            out_tdata[OUT_DATA_W-1:3+TOTAL_W] !== '0) begin
          $display("%0t ERROR result mismatch: expected found=%0d status=%0d total=%0d last=%0d,",
                   $time, want.found, want.status, want.total, want.last);
          $display("%0t   got found=%0d status=%0d total=%0d last=%0d pad=%0d",
                   $time, out_tdata[0], out_tdata[2:1], out_tdata[3 +: TOTAL_W],
                   out_tlast, out_tdata[OUT_DATA_W-1:3+TOTAL_W]);
          mismatch_count++;
        end
      end
    end
  end

  // sequencer
  initial begin : sequencer
    int need;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty set, extremes, duplicates, lookups, both batch marks
    queue_row(OP_QUERY,  ROW_MIN, 1'b0);    // lookup in an empty set
    queue_row(OP_INSERT, '0, 1'b1);
    queue_row(OP_INSERT, ROW_MIN, 1'b0);
    queue_row(OP_INSERT, ROW_MAX, 1'b0);
    queue_row(OP_INSERT, '1, 1'b0);
    queue_row(OP_INSERT, 64'sd1, 1'b1);
    queue_row(OP_INSERT, ROW_MIN, 1'b0);    // duplicate at the low end
    queue_row(OP_INSERT, ROW_MAX, 1'b1);    // duplicate at the high end
    queue_row(OP_QUERY,  ROW_MIN, 1'b0);
    queue_row(OP_QUERY,  ROW_MAX, 1'b0);
    queue_row(OP_QUERY,  '0, 1'b1);
    queue_row(OP_QUERY,  '1, 1'b0);
    queue_row(OP_QUERY,  64'sd2, 1'b0);     // absent, between neighbors
    queue_row(OP_QUERY,  ROW_MAX - 1, 1'b0);
    queue_row(OP_QUERY,  ROW_MIN + 1, 1'b0);
    queue_row(OP_INSERT, 64'h5555_5555_5555_5555, 1'b0);
    queue_row(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    queue_row(OP_QUERY,  64'h5555_5555_5555_5555, 1'b1);
    queue_row(OP_INSERT, '0, 1'b1);         // duplicate with batch mark
    queue_row(OP_QUERY,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    wait_drained();

    // random, no idling
    queue_random_rows(200, 50);
    wait_drained();

    // random, sender mostly idle
    send_idle_pct = 72;
    queue_random_rows(200, 50);
    wait_drained();

    // random, receiver mostly stalled, plus a long hold-off while items keep coming
    send_idle_pct = 0;
    stall_pct = 72;
    queue_random_rows(200, 50);
    hold_trigger++;
    wait_drained();

    // fill the set to capacity with fresh rows, then hit the full and duplicate cases
    send_idle_pct = 33;
    stall_pct = 33;
    need = CAPACITY - held_rows.size();
    for (int i = 0; i < need + 6; i++)
      queue_row(OP_INSERT, {$urandom, $urandom}, $urandom_range(0, 7) == 0);
    queue_row(OP_INSERT, '0, 1'b0);         // duplicate beats full
    queue_row(OP_INSERT, ROW_MIN, 1'b1);
    queue_row(OP_INSERT, ROW_MIN + 1, 1'b0);
    queue_row(OP_QUERY,  '0, 1'b0);
    queue_row(OP_QUERY,  ROW_MIN + 1, 1'b1);
    queue_row(OP_QUERY,  ROW_MAX, 1'b0);
    wait_drained();

    // random traffic against the full set
    queue_random_rows(300, 50);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d items (%0d inserts, %0d duplicates, %0d full drops, %0d hits),",
             items_sent, insert_count, dup_count, full_count, query_hits);
    $display("%0d results checked, %0d cycles of input backpressure, final set size %0d",
             results_checked, backpressure_cycles, held_rows.size());
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("%0t ERROR timeout with %0d results outstanding", $time, expected_results.size());
    $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/srs_pkg.sv
hw/rtl/srs_cell.sv
hw/rtl/srs_or_tree.sv
hw/rtl/sorted_row_set_insert_lookup.sv
verif/sorted_row_set_insert_lookup_tb.sv
